@@ sv/dcma_pkg.sv @@
// ----------------------------------------------------------------------------
// dcma_pkg
// Shared types and constants for the DC offset moving average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dcma_pkg;

  localparam int unsigned FIELD_W    = 32;  // sample / filtered port width
  localparam int unsigned ACC_W      = 48;  // offset accumulator width
  localparam int unsigned CFG_DATA_W = 6;   // widest config register
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_AVG,
    ST_DIFF,
    ST_ACC,
    ST_MEAN,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ sv/dcma_if.sv @@
// ----------------------------------------------------------------------------
// dcma_if
// Valid/ready stream interfaces for the sample and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcma_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dcma_pkg::FIELD_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dcma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dcma_pkg::FIELD_W-1:0]  filtered;
  logic                                 saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

@@ sv/dcma_div.sv @@
// ----------------------------------------------------------------------------
// dcma_div
// Radix-2 restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcma_div #(
  parameter int unsigned DVD_W = 48,
  parameter int unsigned DVS_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start_i,
  input  wire logic signed [DVD_W-1:0]  dividend_i,
  input  wire logic        [DVS_W-1:0]  divisor_i,
  output      logic                     done_o,
  output      logic signed [DVD_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= dividend_i[DVD_W-1];
      dvd_r <= dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= ge ? DVS_W'(shifted - {1'b0, dvs_r}) : DVS_W'(shifted);
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_r;
  assign quotient_o = neg_r ? $signed(-dvd_r) : $signed(dvd_r);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without finishing iteration");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0 || $past(start_i) == 1'b0)
    else $error("iteration count left over");

endmodule

`default_nettype wire

@@ sv/dc_offset_moving_average_unit.sv @@
// ----------------------------------------------------------------------------
// dc_offset_moving_average_unit
// DC offset removal by moving average over signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one sample per transfer (valid/ready).
//   out_ch : one result per sample: filtered value and saturation flag.
//   cfg_*  : write-only registers window_size (0 = pass through) and
//            output_mode (0 = offset-removed sample, 1 = accumulated mean).
//            Write them only while the unit is idle.
// Timing: window samples live in a single-port RAM (read old, write new).
//   The mean comes from a serial divider of DIV_W bits (48 at defaults),
//   one quotient bit per cycle. Pass through goes straight to ST_OUT;
//   mode 0 first runs ST_UPD, ST_AVG (divide) and ST_DIFF; mode 1 adds
//   ST_ACC and ST_MEAN (second divide) before ST_OUT. One sample is
//   worked on at a time; the next is taken once the previous result sits
//   in the output register.
// Reset: window empty, accumulator zero, registers zero. The RAM needs no
//   clearing; only entries inside the fill count are read.
// Stall: a held result blocks the next result from loading; the unit takes
//   one more sample and waits with its result until out_ch drains.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_offset_moving_average_unit #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dcma_in_if.sink                                in_ch,
  dcma_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [dcma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dcma_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned OW     = FILL_W + 1;
  localparam int unsigned TOT_W  = SB + FILL_W;
  localparam int unsigned ACC_W  = dcma_pkg::ACC_W;
  localparam int unsigned DIV_W  = (TOT_W > ACC_W) ? TOT_W : ACC_W;
  localparam int unsigned DIFF_W = SB + 1;
  localparam int unsigned SUM_W  = ((ACC_W > DIFF_W) ? ACC_W : DIFF_W) + 1;

  localparam logic signed [SB-1:0]    S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]    S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] A_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  dcma_pkg::state_t state_r, state_nxt;

  logic [dcma_pkg::CFG_DATA_W-1:0] window_size_r;
  logic                            output_mode_r;

  logic [IDX_W-1:0]          slot_r;
  logic [FILL_W-1:0]         fill_r;
  logic signed [TOT_W-1:0]   total_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic signed [SB-1:0]      win_mem [MAX_WINDOW];
  logic signed [SB-1:0]      rd_data_r;

  logic signed [SB-1:0]      s_r;
  logic                      drop_r;
  logic                      mode_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [SB-1:0]      res_r;
  logic                      hit_r;

  logic                                out_valid_r;
  logic signed [dcma_pkg::FIELD_W-1:0] out_filtered_r;
  logic                                out_saturated_r;

  logic                      in_ready;
  logic                      in_acc;
  logic                      upd_en;
  logic                      out_load;
  logic signed [SB-1:0]      s_in;
  logic [FILL_W-1:0]         w_now;
  logic [OW-1:0]             old_raw;
  logic [IDX_W-1:0]          old_idx;
  logic signed [SB-1:0]      drop_val;
  logic signed [TOT_W-1:0]   total_nxt;
  logic [FILL_W-1:0]         fill_nxt;
  logic [IDX_W-1:0]          slot_nxt;

  logic                      div_start;
  logic signed [DIV_W-1:0]   div_dvd;
  logic [FILL_W-1:0]         div_dvs;
  logic                      div_done;
  logic signed [DIV_W-1:0]   div_q;

  logic signed [SB-1:0]      diff_clamped;
  logic                      diff_clip;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   acc_clamped;
  logic                      acc_clip;
  logic signed [SB-1:0]      mean_clamped;
  logic                      mean_clip;

  // ---- input sample to SAMPLE_BITS ----
  if (SB <= dcma_pkg::FIELD_W) begin : g_narrow
    assign s_in = $signed(in_ch.sample[SB-1:0]);
  end else begin : g_wide
    assign s_in = $signed({{(SB-dcma_pkg::FIELD_W){1'b0}}, in_ch.sample});
  end

  assign w_now = (32'(window_size_r) > 32'(MAX_WINDOW)) ? FILL_W'(MAX_WINDOW)
                                                         : FILL_W'(window_size_r);

  always_comb begin
    old_raw = OW'(slot_r) - OW'(fill_r);
    if (old_raw[OW-1]) begin
      old_raw = old_raw + OW'(MAX_WINDOW);
    end
    old_idx = old_raw[IDX_W-1:0];
  end

  assign drop_val  = drop_r ? rd_data_r : '0;
  assign total_nxt = total_r - TOT_W'(drop_val) + TOT_W'(s_r);
  assign fill_nxt  = drop_r ? fill_r : fill_r + FILL_W'(1);
  assign slot_nxt  = (slot_r == IDX_W'(MAX_WINDOW - 1)) ? '0 : slot_r + IDX_W'(1);

  // ---- clamps ----
  always_comb begin
    diff_clip    = 1'b1;
    diff_clamped = SB'(diff_r);
    if (diff_r > DIFF_W'(S_MAX)) begin
      diff_clamped = S_MAX;
    end else if (diff_r < DIFF_W'(S_MIN)) begin
      diff_clamped = S_MIN;
    end else begin
      diff_clip = 1'b0;
    end

    acc_sum     = SUM_W'(acc_r) + SUM_W'(diff_r);
    acc_clip    = 1'b1;
    acc_clamped = ACC_W'(acc_sum);
    if (acc_sum > SUM_W'(A_MAX)) begin
      acc_clamped = A_MAX;
    end else if (acc_sum < SUM_W'(A_MIN)) begin
      acc_clamped = A_MIN;
    end else begin
      acc_clip = 1'b0;
    end

    mean_clip    = 1'b1;
    mean_clamped = SB'(div_q);
    if (div_q > DIV_W'(S_MAX)) begin
      mean_clamped = S_MAX;
    end else if (div_q < DIV_W'(S_MIN)) begin
      mean_clamped = S_MIN;
    end else begin
      mean_clip = 1'b0;
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    upd_en    = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_dvd   = DIV_W'(acc_r);
    div_dvs   = fill_r;
    unique case (state_r)
      dcma_pkg::ST_IDLE: begin
        in_ready = rst_n;
        if (in_ch.valid) begin
          state_nxt = (w_now == '0) ? dcma_pkg::ST_OUT : dcma_pkg::ST_UPD;
        end
      end
      dcma_pkg::ST_UPD: begin
        upd_en    = 1'b1;
        div_start = 1'b1;
        div_dvd   = DIV_W'(total_nxt);
        div_dvs   = fill_nxt;
        state_nxt = dcma_pkg::ST_AVG;
      end
      dcma_pkg::ST_AVG: begin
        if (div_done) begin
          state_nxt = dcma_pkg::ST_DIFF;
        end
      end
      dcma_pkg::ST_DIFF: begin
        state_nxt = mode_r ? dcma_pkg::ST_ACC : dcma_pkg::ST_OUT;
      end
      dcma_pkg::ST_ACC: begin
        div_start = 1'b1;
        state_nxt = dcma_pkg::ST_MEAN;
      end
      dcma_pkg::ST_MEAN: begin
        if (div_done) begin
          state_nxt = dcma_pkg::ST_OUT;
        end
      end
      dcma_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = dcma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcma_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_acc = in_ch.valid && in_ready;

  // ---- control and filter state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dcma_pkg::ST_IDLE;
      window_size_r <= '0;
      output_mode_r <= 1'b0;
      slot_r        <= '0;
      fill_r        <= '0;
      total_r       <= '0;
      acc_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dcma_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_wdata;
          dcma_pkg::CFG_OUTPUT_MODE: output_mode_r <= cfg_wdata[0];
        endcase
      end
      if (upd_en) begin
        total_r <= total_nxt;
        fill_r  <= fill_nxt;
        slot_r  <= slot_nxt;
      end
      if (state_r == dcma_pkg::ST_DIFF && mode_r) begin
        acc_r <= acc_clamped;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- window RAM ----
  always_ff @(posedge clk) begin
    if (upd_en) begin
      win_mem[slot_r] <= s_r;
    end
    if (in_acc) begin
      rd_data_r <= win_mem[old_idx];
    end
  end

  // ---- item datapath ----
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_r    <= s_in;
      res_r  <= s_in;
      hit_r  <= 1'b0;
      mode_r <= output_mode_r;
      drop_r <= fill_r >= w_now;
    end
    if (state_r == dcma_pkg::ST_AVG && div_done) begin
      diff_r <= DIFF_W'(s_r) - DIFF_W'(div_q);
    end
    if (state_r == dcma_pkg::ST_DIFF) begin
      if (mode_r) begin
        hit_r <= hit_r | acc_clip;
      end else begin
        res_r <= diff_clamped;
        hit_r <= hit_r | diff_clip;
      end
    end
    if (state_r == dcma_pkg::ST_MEAN && div_done) begin
      res_r <= mean_clamped;
      hit_r <= hit_r | mean_clip;
    end
    if (out_load) begin
      out_filtered_r  <= dcma_pkg::FIELD_W'(res_r);
      out_saturated_r <= hit_r;
    end
  end

  dcma_div #(
    .DVD_W (DIV_W),
    .DVS_W (FILL_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.filtered  = out_filtered_r;
  assign out_ch.saturated = out_saturated_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_WINDOW))
    else $error("fill count beyond window depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < 32'(MAX_WINDOW))
    else $error("write slot beyond window depth");

  a_pass_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && w_now == '0) |=> fill_r == $past(fill_r) && slot_r == $past(slot_r))
    else $error("pass-through sample changed window state");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dcma_pkg::ST_UPD |=> fill_r != '0)
    else $error("window empty after update");

endmodule

`default_nettype wire
